// ===== rtl/encoder_angle_tracker_macros.svh =====
// Assertion macros used by the angle tracker top module.
// Depends on nothing; included by the files that carry checks.
`ifndef ENCODER_ANGLE_TRACKER_MACROS_SVH
`define ENCODER_ANGLE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define EAT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("encoder_angle_tracker: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define EAT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("encoder_angle_tracker: next-cycle check failed");

`endif

// ===== rtl/eat_pkg.sv =====
// Shared constants, codes and types of the encoder angle tracker.
// Depends on nothing; used by every module of the block.
package eat_pkg;

  localparam int EAT_ANGLE_BITS       = 12;
  localparam int EAT_TICKS_PER_SECOND = 1000000;

  localparam int RAW_W     = 12;
  localparam int TIME_W    = 32;
  localparam int POS_W     = 32;
  localparam int OFF_W     = 12;
  localparam int ALPHA_W   = 17;
  localparam int DBAND_W   = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W     = 2;
  localparam int S_DATA_W  = 80;
  localparam int S_USER_W  = 2;
  localparam int M_DATA_W  = 80;
  localparam int Q16_FRAC  = 16;
  localparam int Q16_HALF  = 32768;

  localparam logic [ALPHA_W-1:0] Q16_ONE     = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h08000;

  localparam logic [REQ_W-1:0] REQ_PRIME  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } eat_unit_status_t;

endpackage

// ===== rtl/eat_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on eat_pkg for the status type.
module eat_sdiv import eat_pkg::*; #(
  parameter int NW = 31,
  parameter int DW = TIME_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NW-1:0]    dividend,
  input  logic [DW-1:0]    divisor,
  output logic [NW-1:0]    quotient,
  output eat_unit_status_t status
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW+1:0] trial;
  logic          ge;

  assign trial = {1'b0, rem, quo[NW-1]} - {2'b00, dvs};
  assign ge    = !trial[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[DW-1:0] : {rem[DW-2:0], quo[NW-1]};
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/eat_sfilt.sv =====
// Exponential velocity filter with a shift-add multiply over the alpha bits.
// Depends on eat_pkg for widths, Q16 constants and the status type.
module eat_sfilt import eat_pkg::*; #(
  parameter int RW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [RW-1:0]    raw_vel,
  input  logic signed [POS_W-1:0] old_vel,
  input  logic [ALPHA_W-1:0]      alpha,
  output logic signed [POS_W-1:0] vel,
  output eat_unit_status_t        status
);

  localparam int DFW = ((RW > POS_W) ? RW : POS_W) + 1;
  localparam int PRW = DFW + ALPHA_W;
  localparam int SW  = PRW + 1;
  localparam int YW  = SW - Q16_FRAC;
  localparam int CW  = $clog2(ALPHA_W + 1);
  localparam logic signed [YW-1:0] Y_MAX = YW'(2147483647);
  localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

  logic signed [DFW-1:0]   diff;
  logic [ALPHA_W-1:0]      abits;
  logic signed [PRW-1:0]   acc;
  logic signed [PRW-1:0]   addend;
  logic signed [POS_W-1:0] vold;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic                    done;
  logic signed [SW-1:0]    sum;
  logic signed [YW-1:0]    y;
  logic signed [POS_W-1:0] y_sat;

  // Result is vold + alpha * (raw - vold) / 2^16, rounded half up.
  assign addend = abits[ALPHA_W-1] ? PRW'(diff) : PRW'(0);
  assign sum    = SW'(acc) + (SW'(vold) <<< Q16_FRAC) + SW'(Q16_HALF);
  assign y      = $signed(sum[SW-1:Q16_FRAC]);

  always_comb begin
    if (y > Y_MAX) begin
      y_sat = 32'sh7FFFFFFF;
    end else if (y < Y_MIN) begin
      y_sat = 32'sh80000000;
    end else begin
      y_sat = y[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(ALPHA_W);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - CW'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff  <= DFW'(raw_vel) - DFW'(old_vel);
      abits <= (alpha > Q16_ONE) ? Q16_ONE : alpha;
      acc   <= '0;
      vold  <= old_vel;
    end else if (busy) begin
      if (cnt != '0) begin
        acc   <= (acc <<< 1) + addend;
        abits <= {abits[ALPHA_W-2:0], 1'b0};
      end else begin
        vel <= y_sat;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/encoder_angle_tracker.sv =====
// Multi-turn position and filtered velocity tracker for an absolute angle sensor.
// Depends on eat_pkg, eat_sdiv, eat_sfilt and encoder_angle_tracker_macros.svh.
//
// The sensor side delivers one word per sample on s_tvalid/s_tready: the
// request kind in s_tuser and the angle, elapsed ticks and target in s_tdata.
// Each word yields exactly one result word on m_tvalid/m_tready with the
// position, the filtered velocity and the offset found by a set request.
// The block holds one request at a time. Prime, set, the unused kind, and
// an update with zero elapsed time go from idle straight to the finish
// state, which loads the result into the output register; the next word
// is taken only once the block is back in idle. An update with nonzero
// elapsed time forms the velocity through a bit-serial divider, one quotient
// bit per cycle over ANGLE_BITS-1+clog2(TICKS_PER_SECOND+1) bits, and a
// 17-step shift-add filter multiply before it reaches the finish state.
// The result sits in an output register; while the receiver stalls, the
// next word is still taken and worked on, and only its result waits.
// Synchronous reset clears position, velocity, last angle, offset,
// direction and deadband, sets alpha to ALPHA_RESET, drops any pending result.
`include "encoder_angle_tracker_macros.svh"
module encoder_angle_tracker import eat_pkg::*; #(
  parameter int ANGLE_BITS       = EAT_ANGLE_BITS,
  parameter int TICKS_PER_SECOND = EAT_TICKS_PER_SECOND
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // sensor_angle, elapsed_us, target_position
  input  logic [S_USER_W-1:0]  s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // position, velocity, new_offset
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = ANGLE_BITS;
  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int MW    = AW + TPS_W;
  localparam int PW    = MW - 1;
  localparam int RW    = PW + 1;
  localparam int DBW   = (PW > DBAND_W) ? PW : DBAND_W;
  localparam int EW    = ((AW > RAW_W) ? AW : RAW_W) + 2;
  localparam int HALF  = 1 << (AW - 1);
  localparam int TURN  = 1 << AW;
  localparam int PAD_W = M_DATA_W - 2 * POS_W - OFF_W;

  localparam logic signed [AW+1:0] HALF_D = (AW + 2)'(HALF);
  localparam logic signed [AW+1:0] TURN_D = (AW + 2)'(TURN);
  localparam logic signed [EW-1:0] HALF_E = EW'(HALF);
  localparam logic signed [EW-1:0] TURN_E = EW'(TURN);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_FSTART = 3'd3;
  localparam logic [2:0] ST_FILT   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state;

  logic signed [RAW_W-1:0] zero_offset;
  logic                    direction_negative;
  logic [ALPHA_W-1:0]      smoothing_alpha;
  logic [DBAND_W-1:0]      velocity_deadband;

  logic [AW-1:0]           last_angle;
  logic [POS_W-1:0]        accumulated_position;
  logic signed [POS_W-1:0] filtered_velocity;

  logic [REQ_W-1:0]  item_req;
  logic [AW-1:0]     item_raw;
  logic [TIME_W-1:0] item_elapsed;
  logic [POS_W-1:0]  item_target;
  logic signed [AW:0] d_reg;
  logic              vel_upd;
  logic signed [RW-1:0] rv_reg;

  logic [POS_W-1:0]        out_pos;
  logic signed [POS_W-1:0] out_vel;
  logic [OFF_W-1:0]        out_off;

  logic [RAW_W-1:0]  in_raw;
  logic [TIME_W-1:0] in_elapsed;
  logic [POS_W-1:0]  in_target;
  logic [REQ_W-1:0]  in_req;
  logic              in_timed;
  logic [AW-1:0]     raw_a;
  logic signed [AW+1:0] dd;
  logic signed [AW+1:0] dw;
  logic signed [AW+1:0] dn;

  logic [AW-1:0]     d_mag;
  logic [MW-1:0]     prod;
  logic [PW-1:0]     quo;
  logic              below_band;
  logic signed [RW-1:0] rv_next;

  logic signed [EW-1:0] sa;
  logic signed [EW-1:0] c0;
  logic signed [EW-1:0] cw;
  logic signed [EW-1:0] cp;
  logic [AW-1:0]        m_off;
  logic signed [EW-1:0] off_e;

  logic [POS_W-1:0]        pos_next;
  logic signed [POS_W-1:0] vel_next;
  logic [OFF_W-1:0]        off_next;
  logic                    accept;
  logic                    out_free;
  logic                    div_start;
  logic                    filt_start;
  logic signed [POS_W-1:0] filt_vel;
  eat_unit_status_t        div_st;
  eat_unit_status_t        filt_st;

  assign in_raw     = s_tdata[RAW_W-1:0];
  assign in_elapsed = s_tdata[RAW_W +: TIME_W];
  assign in_target  = s_tdata[RAW_W + TIME_W +: POS_W];
  assign in_req     = s_tuser;
  assign in_timed   = (in_req == REQ_UPDATE) && (in_elapsed != '0);

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign div_start  = (state == ST_MUL);
  assign filt_start = (state == ST_FSTART);

  // Angle step since the last sample, wrapped to half a turn.
  assign raw_a = AW'(in_raw);
  assign dd    = $signed({2'b00, raw_a}) - $signed({2'b00, last_angle});

  always_comb begin
    if (dd > HALF_D) begin
      dw = dd - TURN_D;
    end else if (dd < -HALF_D) begin
      dw = dd + TURN_D;
    end else begin
      dw = dd;
    end
  end

  assign dn = direction_negative ? -dw : dw;

  assign d_mag = d_reg[AW] ? AW'(-d_reg) : AW'(d_reg);
  assign prod  = MW'(d_mag) * MW'(TICKS_PER_SECOND);

  eat_sdiv #(
    .NW(PW),
    .DW(TIME_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod[PW-1:0]),
    .divisor (item_elapsed),
    .quotient(quo),
    .status  (div_st)
  );

  assign below_band = DBW'(quo) < DBW'(velocity_deadband);
  assign rv_next    = below_band ? '0 :
                      (d_reg[AW] ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));

  eat_sfilt #(
    .RW(RW)
  ) u_filt (
    .clk    (clk),
    .rst    (rst),
    .start  (filt_start),
    .raw_vel(rv_reg),
    .old_vel(filtered_velocity),
    .alpha  (smoothing_alpha),
    .vel    (filt_vel),
    .status (filt_st)
  );

  // Prime: signed angle less the stored offset, wrapped once, then directed.
  assign sa = (item_raw > AW'(HALF)) ? $signed(EW'(item_raw)) - TURN_E
                                     : $signed(EW'(item_raw));
  assign c0 = sa - EW'(zero_offset);

  always_comb begin
    if (c0 > HALF_E) begin
      cw = c0 - TURN_E;
    end else if (c0 < -HALF_E) begin
      cw = c0 + TURN_E;
    end else begin
      cw = c0;
    end
  end

  assign cp = direction_negative ? -cw : cw;

  assign m_off = item_raw - item_target[AW-1:0];
  assign off_e = EW'($signed(m_off));

  always_comb begin
    pos_next = accumulated_position;
    vel_next = filtered_velocity;
    off_next = '0;
    case (item_req)
      REQ_PRIME: begin
        pos_next = POS_W'(cp);
        vel_next = '0;
      end
      REQ_UPDATE: begin
        pos_next = accumulated_position + POS_W'(d_reg);
        if (vel_upd) begin
          vel_next = filt_vel;
        end
      end
      REQ_SET: begin
        pos_next = item_target;
        off_next = off_e[OFF_W-1:0];
      end
      default: begin
        off_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset        <= '0;
      direction_negative <= 1'b0;
      smoothing_alpha    <= ALPHA_RESET;
      velocity_deadband  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZERO_OFFSET: zero_offset        <= cfg_data[RAW_W-1:0];
        CFG_DIRECTION:   direction_negative <= cfg_data[0];
        CFG_ALPHA:       smoothing_alpha    <= cfg_data[ALPHA_W-1:0];
        CFG_DEADBAND:    velocity_deadband  <= cfg_data[DBAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      m_tvalid             <= 1'b0;
      last_angle           <= '0;
      accumulated_position <= '0;
      filtered_velocity    <= '0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= in_timed ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_FSTART;
          end
        end
        ST_FSTART: begin
          state <= ST_FILT;
        end
        ST_FILT: begin
          if (filt_st.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            accumulated_position <= pos_next;
            filtered_velocity    <= vel_next;
            if (item_req == REQ_PRIME || item_req == REQ_UPDATE || item_req == REQ_SET) begin
              last_angle <= item_raw;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_req     <= in_req;
      item_raw     <= raw_a;
      item_elapsed <= in_elapsed;
      item_target  <= in_target;
      d_reg        <= dn[AW:0];
      vel_upd      <= in_timed;
    end
    if (state == ST_DIV && div_st.done) begin
      rv_reg <= rv_next;
    end
    if (state == ST_FIN && out_free) begin
      out_pos <= pos_next;
      out_vel <= vel_next;
      out_off <= off_next;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_off, out_vel, out_pos};

  `EAT_ASSERT_NXT(a_one_item, clk, rst, accept, !s_tready)
  `EAT_ASSERT_IMP(a_units_exclusive, clk, rst, div_st.busy, !filt_st.busy)
  `EAT_ASSERT_IMP(a_idle_units_quiet, clk, rst, s_tready, !div_st.busy && !filt_st.busy)
  `EAT_ASSERT_IMP(a_filter_timed_only, clk, rst, filt_start,
                  item_req == REQ_UPDATE && item_elapsed != '0)

endmodule
